FILE: sv/pfs_pkg.sv
// shared types and constants for the printf format stream core
// no dependencies; imported by every module of the block

package pfs_pkg;

    // pointer width used by the pointer conversion
    localparam int ARG_BITS = 64;
    localparam logic [63:0] ARG_MASK = {64{1'b1}} >> (64 - ARG_BITS);

    // digit stack sizing: 16 hex digits is the longest number
    localparam int DIG_DEPTH = 16;
    localparam int DIG_IDX_W = $clog2(DIG_DEPTH);
    localparam int DIG_CNT_W = $clog2(DIG_DEPTH + 1);

    // reciprocal of ten for a 32-bit dividend, shift of 35
    localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;
    localparam int RECIP_SHIFT = 35;

    // ascii codes
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] CH_LC_D  = 8'h64;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_LC_P  = 8'h70;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // digit stack control
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_buf_ctrl;

endpackage

FILE: sv/pfs_digit_unit.sv
// shared digit unit: one divide-by-ten or shift-by-four step per cycle
// depends on pfs_pkg

module pfs_digit_unit (
    input  logic [63:0] i_value,
    input  logic        i_hex,
    output logic [63:0] o_quot,
    output logic [3:0]  o_digit
);
    import pfs_pkg::*;

    logic [31:0] dec_in;
    logic [63:0] prod;
    logic [28:0] dec_q;
    logic [31:0] dec_q10;
    logic [31:0] dec_rem;

    // decimal step via reciprocal multiply, remainder by shift-add
    always_comb begin
        dec_in  = i_value[31:0];
        prod    = 64'(dec_in) * 64'(RECIP_10);
        dec_q   = prod[63:RECIP_SHIFT];
        dec_q10 = {dec_q[28:0], 3'b000} + {2'b00, dec_q[28:0], 1'b0};
        dec_rem = dec_in - dec_q10;
    end

    // select hex or decimal step
    always_comb begin
        if (i_hex) begin
            o_quot  = {4'h0, i_value[63:4]};
            o_digit = i_value[3:0];
        end else begin
            o_quot  = {35'd0, dec_q};
            o_digit = dec_rem[3:0];
        end
    end

endmodule

FILE: sv/pfs_digit_buf.sv
// digit stack: digits are pushed least significant first, popped most first
// depends on pfs_pkg

module pfs_digit_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pfs_pkg::t_buf_ctrl          i_ctrl,
    input  logic [3:0]                  i_digit,
    output logic [3:0]                  o_top,
    output logic [pfs_pkg::DIG_CNT_W-1:0] o_count
);
    import pfs_pkg::*;

    logic [3:0]           r_stk [DIG_DEPTH];
    logic [DIG_CNT_W-1:0] r_cnt;
    logic [DIG_CNT_W-1:0] n_cnt;

    // fill count
    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.clear) begin
            n_cnt = '0;
        end else if (i_ctrl.push) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_ctrl.pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // digit storage: shift up on push, down on pop, top sits in entry zero
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && !i_ctrl.clear) begin
            r_stk[0] <= i_digit;
            for (int k = 1; k < DIG_DEPTH; k++) begin
                r_stk[k] <= r_stk[k-1];
            end
        end else if (i_ctrl.pop && !i_ctrl.clear) begin
            for (int k = 0; k < DIG_DEPTH - 1; k++) begin
                r_stk[k] <= r_stk[k+1];
            end
        end
    end

    assign o_top   = r_stk[0];
    assign o_count = r_cnt;

endmodule

FILE: sv/printf_format_stream_core.sv
// printf format stream core: one format byte per input beat, ascii out
// steps: the format byte is decoded into registers, then the digit unit
// pushes one digit per cycle onto the stack, then the prefix chars and the
// popped digits each go out as an output beat while the output is not stalled
// input is stalled while an item is in flight; output register holds a beat
// reset (synchronous, active low) clears the percent flag, out valid and fsm
// depends on pfs_pkg, pfs_digit_unit, pfs_digit_buf

module printf_format_stream_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_fmt_byte,
    input  logic [63:0] i_arg_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);
    import pfs_pkg::*;

    t_state               r_state, n_state;
    logic                 r_pending, n_pending;
    logic [7:0]           r_pre0, n_pre0;
    logic [7:0]           r_pre1, n_pre1;
    logic [1:0]           r_pre_cnt, n_pre_cnt;
    logic                 r_has_num, n_has_num;
    logic                 r_hex, n_hex;
    logic [7:0]           r_letter, n_letter;
    logic [63:0]          r_val, n_val;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic                 in_acc;
    logic                 out_free;
    logic [63:0]          unit_quot;
    logic [3:0]           unit_digit;
    logic [3:0]           top_digit;
    logic [DIG_CNT_W-1:0] buf_count;
    t_buf_ctrl            buf_ctrl;
    logic [31:0]          arg_lo;
    logic [7:0]           digit_char;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign arg_lo   = i_arg_value[31:0];

    pfs_digit_unit u_unit (
        .i_value (r_val),
        .i_hex   (r_hex),
        .o_quot  (unit_quot),
        .o_digit (unit_digit)
    );

    pfs_digit_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (buf_ctrl),
        .i_digit (unit_digit),
        .o_top   (top_digit),
        .o_count (buf_count)
    );

    // digit to ascii
    always_comb begin
        if (top_digit < 4'd10) begin
            digit_char = CH_ZERO + 8'(top_digit);
        end else begin
            digit_char = r_letter + 8'(top_digit) - 8'd10;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_pre0      = r_pre0;
        n_pre1      = r_pre1;
        n_pre_cnt   = r_pre_cnt;
        n_has_num   = r_has_num;
        n_hex       = r_hex;
        n_letter    = r_letter;
        n_val       = r_val;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        buf_ctrl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pre0    = i_fmt_byte;
                    n_pre1    = i_fmt_byte;
                    n_pre_cnt = 2'd0;
                    n_has_num = 1'b0;
                    n_hex     = 1'b0;
                    n_letter  = CH_LC_A;
                    n_val     = {32'd0, arg_lo};
                    buf_ctrl.clear = 1'b1;
                    if (!r_pending) begin
                        // plain byte echoes, a percent arms the flag
                        if (i_fmt_byte == CH_PCT) begin
                            n_pending = 1'b1;
                        end else begin
                            n_pre_cnt = 2'd1;
                        end
                    end else begin
                        n_pending = 1'b0;
                        unique case (i_fmt_byte) inside
                            CH_LC_C: begin
                                n_pre0    = i_arg_value[7:0];
                                n_pre_cnt = 2'd1;
                            end
                            CH_LC_S: begin
                                n_pre_cnt = 2'd0;
                            end
                            CH_LC_D, CH_LC_I: begin
                                n_has_num = 1'b1;
                                if (arg_lo[31]) begin
                                    n_pre0    = CH_MINUS;
                                    n_pre_cnt = 2'd1;
                                    n_val     = {32'd0, 32'd0 - arg_lo};
                                end
                            end
                            CH_LC_U: begin
                                n_has_num = 1'b1;
                            end
                            CH_LC_X: begin
                                n_has_num = 1'b1;
                                n_hex     = 1'b1;
                            end
                            CH_UC_X: begin
                                n_has_num = 1'b1;
                                n_hex     = 1'b1;
                                n_letter  = CH_UC_A;
                            end
                            CH_LC_P: begin
                                n_has_num = 1'b1;
                                n_hex     = 1'b1;
                                n_pre0    = CH_ZERO;
                                n_pre1    = CH_LC_X;
                                n_pre_cnt = 2'd2;
                                n_val     = i_arg_value & ARG_MASK;
                            end
                            CH_PCT: begin
                                n_pre0    = CH_PCT;
                                n_pre_cnt = 2'd1;
                            end
                            default: begin
                                // unknown conversion: percent then the byte
                                n_pre0    = CH_PCT;
                                n_pre_cnt = 2'd2;
                            end
                        endcase
                    end
                    if (n_has_num) begin
                        n_state = S_CONV;
                    end else if (n_pre_cnt != 2'd0) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CONV: begin
                // one digit per cycle into the stack
                buf_ctrl.push = 1'b1;
                n_val         = unit_quot;
                if (unit_quot == 64'd0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pre_cnt != 2'd0) begin
                        n_out_char = r_pre0;
                        n_out_last = (r_pre_cnt == 2'd1) && !r_has_num;
                        n_pre0     = r_pre1;
                        n_pre_cnt  = r_pre_cnt - 2'd1;
                    end else begin
                        n_out_char   = digit_char;
                        n_out_last   = (buf_count == DIG_CNT_W'(1));
                        buf_ctrl.pop = 1'b1;
                    end
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pre0     <= n_pre0;
        r_pre1     <= n_pre1;
        r_pre_cnt  <= n_pre_cnt;
        r_has_num  <= n_has_num;
        r_hex      <= n_hex;
        r_letter   <= n_letter;
        r_val      <= n_val;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule
